// File: sv/drrip_pkg.sv
// ----------------------------------------------------------------------------
// drrip_pkg
// Shared widths, default sizes, request codes and the bimodal LFSR step for
// the DRRIP replacement block.
// ----------------------------------------------------------------------------
package drrip_pkg;

	// request field widths
	localparam int SET_IDX_W = 11;
	localparam int WAY_IDX_W = 4;
	localparam int VICTIM_W  = 4;

	// default geometry
	localparam int DEF_NUM_SETS     = 2048;
	localparam int DEF_NUM_WAYS     = 16;
	localparam int DEF_RRPV_BITS    = 2;
	localparam int DEF_GROUP_SIZE   = 32;
	localparam int DEF_COUNTER_BITS = 10;
	localparam int DEF_BIMODAL_ODDS = 32;

	// width of dividends that go through the reciprocal multipliers
	localparam int DIV_W  = 16;
	localparam int PROD_W = 2 * DIV_W + 1;

	// bimodal lfsr
	localparam int              LFSR_W    = 16;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

	// request codes
	localparam logic FUNC_VICTIM = 1'b0;
	localparam logic FUNC_UPDATE = 1'b1;

	// fibonacci step, taps 16,14,13,11, new bit enters at the top
	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
		logic b;
		b = v[0] ^ v[2] ^ v[3] ^ v[5];
		return {b, v[LFSR_W-1:1]};
	endfunction

endpackage

// File: sv/drrip_cache_replacement.sv
// ----------------------------------------------------------------------------
// drrip_cache_replacement
// Dynamic re-reference interval prediction with per-group set dueling.
// Per-set re-reference rows live in one memory, group policy counters in a
// second; every request is a read-modify-write of its set row.
// ----------------------------------------------------------------------------
// result strobe (done) is registered in ST_EXEC, after ST_FOLD, ST_MUL and ST_GRP
// a new request is taken only in idle, once the last one is done; index fold, reciprocal multiply with
//   the set row read, counter read and write-back run one after another
// receiver cannot stall: done lasts one cycle, a new request may start then
// reset: a clearing pass (busy high) fills every row with the maximum
//   value and zeroes the group counters
module drrip_cache_replacement
	import drrip_pkg::*;
#(
	parameter int NUM_SETS     = DEF_NUM_SETS,
	parameter int NUM_WAYS     = DEF_NUM_WAYS,
	parameter int RRPV_BITS    = DEF_RRPV_BITS,
	parameter int GROUP_SIZE   = DEF_GROUP_SIZE,
	parameter int COUNTER_BITS = DEF_COUNTER_BITS,
	parameter int BIMODAL_ODDS = DEF_BIMODAL_ODDS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 func,
	input  logic [SET_IDX_W-1:0] set_index,
	input  logic [WAY_IDX_W-1:0] way_index,
	input  logic                 hit,
	output logic                 done,
	output logic [VICTIM_W-1:0]  victim_way,
	output logic                 used_srrip
);

	// geometry
	localparam int SA_W       = $clog2(NUM_SETS);
	localparam int WAY_W      = $clog2(NUM_WAYS);
	localparam int ROW_W      = NUM_WAYS * RRPV_BITS;
	localparam int NVAL       = 1 << RRPV_BITS;
	localparam int NUM_GROUPS = (NUM_SETS + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

	// conditional-subtract steps that fold the request indexes into range
	localparam int SET_FOLD = (SET_IDX_W + 1 > SA_W) ? SET_IDX_W + 1 - SA_W : 0;
	localparam int WAY_FOLD = (WAY_IDX_W + 1 > WAY_W) ? WAY_IDX_W + 1 - WAY_W : 0;

	// exact reciprocals for 16-bit dividends
	localparam int GRP_SH = DIV_W + $clog2(GROUP_SIZE);
	localparam int ODD_SH = DIV_W + $clog2(BIMODAL_ODDS);
	localparam logic [DIV_W:0] GRP_MUL = (DIV_W + 1)'(((64'd1 << GRP_SH)
		+ 64'(GROUP_SIZE) - 64'd1) / 64'(GROUP_SIZE));
	localparam logic [DIV_W:0] ODD_MUL = (DIV_W + 1)'(((64'd1 << ODD_SH)
		+ 64'(BIMODAL_ODDS) - 64'd1) / 64'(BIMODAL_ODDS));

	// rrpv and counter constants
	localparam logic [RRPV_BITS-1:0]    RMAX     = '1;
	localparam logic [RRPV_BITS-1:0]    RLONG    = RRPV_BITS'(RMAX - RRPV_BITS'(1));
	localparam logic [COUNTER_BITS-1:0] CTR_MAX  = '1;
	localparam logic [COUNTER_BITS-1:0] CTR_HALF = COUNTER_BITS'(1) << (COUNTER_BITS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FOLD,
		ST_MUL,
		ST_GRP,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic [SA_W-1:0] clr_idx_q;

	// request registers
	logic                 func_q;
	logic                 hit_q;
	logic [SET_IDX_W-1:0] set_raw_q;
	logic [WAY_IDX_W-1:0] way_raw_q;
	logic [SA_W-1:0]      set_q;
	logic [WAY_W-1:0]     way_q;
	logic [PROD_W-1:0]    prod_set_q;
	logic [PROD_W-1:0]    prod_odd_q;
	logic [GRP_W-1:0]     grp_q;
	logic                 leader_q;
	logic                 odd_zero_q;
	logic [LFSR_W-1:0]    lfsr_q;

	// memories and their read registers
	logic [ROW_W-1:0]        row_mem [NUM_SETS];
	logic [COUNTER_BITS-1:0] ctr_mem [NUM_GROUPS];
	logic [ROW_W-1:0]        row_rd_q;
	logic [COUNTER_BITS-1:0] ctr_rd_q;

	// combinational signals
	logic [LFSR_W-1:0]       lfsr_nx;
	logic [PROD_W-1:0]       grp_shift;
	logic [PROD_W-1:0]       odd_shift;
	logic [GRP_W-1:0]        grp_nx;
	logic [DIV_W-1:0]        odd_quot;
	logic [NVAL-1:0]         present;
	logic [RRPV_BITS-1:0]    top;
	logic [RRPV_BITS-1:0]    add;
	logic [WAY_W-1:0]        first_w;
	logic [ROW_W-1:0]        new_row;
	logic                    srrip;
	logic [RRPV_BITS-1:0]    ins_val;
	logic [COUNTER_BITS-1:0] ctr_new;
	logic                    fill;
	logic                    row_we;
	logic [SA_W-1:0]         row_waddr;
	logic [ROW_W-1:0]        row_wdata;
	logic                    ctr_we;
	logic [GRP_W-1:0]        ctr_waddr;
	logic [COUNTER_BITS-1:0] ctr_wdata;

	// fold the raw set index into 0 .. NUM_SETS-1
	function automatic logic [SA_W-1:0] fold_set(input logic [SET_IDX_W-1:0] raw);
		logic [17:0] v;
		v = 18'(raw);
		for (int k = SET_FOLD - 1; k >= 0; k--) begin
			if (v >= (18'(NUM_SETS) << k))
				v = v - (18'(NUM_SETS) << k);
		end
		return v[SA_W-1:0];
	endfunction

	// fold the raw way index into 0 .. NUM_WAYS-1
	function automatic logic [WAY_W-1:0] fold_way(input logic [WAY_IDX_W-1:0] raw);
		logic [7:0] v;
		v = 8'(raw);
		for (int k = WAY_FOLD - 1; k >= 0; k--) begin
			if (v >= (8'(NUM_WAYS) << k))
				v = v - (8'(NUM_WAYS) << k);
		end
		return v[WAY_W-1:0];
	endfunction

	assign busy = (state_q != ST_IDLE);

	// control sequence and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_idx_q  <= '0;
			done       <= 1'b0;
			victim_way <= '0;
			used_srrip <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_idx_q == SA_W'(NUM_SETS - 1))
						state_q <= ST_IDLE;
					clr_idx_q <= clr_idx_q + SA_W'(1);
				end
				ST_IDLE: begin
					if (start)
						state_q <= ST_FOLD;
				end
				ST_FOLD: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_GRP;
				ST_GRP:  state_q <= ST_EXEC;
				ST_EXEC: begin
					state_q    <= ST_IDLE;
					done       <= 1'b1;
					victim_way <= (func_q == FUNC_VICTIM) ? VICTIM_W'(first_w) : '0;
					used_srrip <= fill && srrip;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// bimodal lfsr, advanced on bimodal fills only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_SEED;
		end else if (state_q == ST_EXEC && fill && !srrip) begin
			lfsr_q <= lfsr_nx;
		end
	end

	assign lfsr_nx   = lfsr_next(lfsr_q);
	assign grp_shift = prod_set_q >> GRP_SH;
	assign odd_shift = prod_odd_q >> ODD_SH;
	assign grp_nx    = grp_shift[GRP_W-1:0];
	assign odd_quot  = odd_shift[DIV_W-1:0];

	// request pipeline registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			func_q    <= func;
			hit_q     <= hit;
			set_raw_q <= set_index;
			way_raw_q <= way_index;
		end
		if (state_q == ST_FOLD) begin
			set_q <= fold_set(set_raw_q);
			way_q <= fold_way(way_raw_q);
		end
		if (state_q == ST_MUL) begin
			prod_set_q <= PROD_W'(DIV_W'(set_q)) * PROD_W'(GRP_MUL);
			prod_odd_q <= PROD_W'(lfsr_nx) * PROD_W'(ODD_MUL);
		end
		if (state_q == ST_GRP) begin
			grp_q      <= grp_nx;
			leader_q   <= (32'(grp_nx) * 32'(GROUP_SIZE)) == 32'(set_q);
			odd_zero_q <= (32'(odd_quot) * 32'(BIMODAL_ODDS)) == 32'(lfsr_nx);
		end
	end

	// victim search, aging and row update
	always_comb begin
		present = '0;
		for (int w = 0; w < NUM_WAYS; w++)
			present[row_rd_q[w*RRPV_BITS +: RRPV_BITS]] = 1'b1;
		top = '0;
		for (int i = 0; i < NVAL; i++) begin
			if (present[i])
				top = RRPV_BITS'(i);
		end
		first_w = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (row_rd_q[w*RRPV_BITS +: RRPV_BITS] == top)
				first_w = WAY_W'(w);
		end
		add = RMAX - top;

		fill = (func_q == FUNC_UPDATE) && !hit_q;
		if (leader_q)
			srrip = !grp_q[0];
		else
			srrip = ctr_rd_q > CTR_HALF;
		ins_val = (srrip || odd_zero_q) ? RLONG : RMAX;

		// even leaders count up, odd leaders count down, both saturate
		if (!grp_q[0])
			ctr_new = (ctr_rd_q != CTR_MAX) ? ctr_rd_q + COUNTER_BITS'(1) : ctr_rd_q;
		else
			ctr_new = (ctr_rd_q != '0) ? ctr_rd_q - COUNTER_BITS'(1) : ctr_rd_q;

		new_row = row_rd_q;
		if (func_q == FUNC_VICTIM) begin
			for (int w = 0; w < NUM_WAYS; w++)
				new_row[w*RRPV_BITS +: RRPV_BITS] = row_rd_q[w*RRPV_BITS +: RRPV_BITS] + add;
		end else if (hit_q) begin
			new_row[way_q*RRPV_BITS +: RRPV_BITS] = '0;
		end else begin
			new_row[way_q*RRPV_BITS +: RRPV_BITS] = ins_val;
		end
	end

	// memory write ports: clearing pass or write-back
	always_comb begin
		row_we    = 1'b0;
		row_waddr = set_q;
		row_wdata = new_row;
		ctr_we    = 1'b0;
		ctr_waddr = grp_q;
		ctr_wdata = ctr_new;
		if (state_q == ST_CLEAR) begin
			row_we    = 1'b1;
			row_waddr = clr_idx_q;
			row_wdata = '1;
			ctr_we    = 32'(clr_idx_q) < 32'(NUM_GROUPS);
			ctr_waddr = clr_idx_q[GRP_W-1:0];
			ctr_wdata = '0;
		end else if (state_q == ST_EXEC) begin
			row_we = 1'b1;
			ctr_we = fill && leader_q;
		end
	end

	// set row memory
	always_ff @(posedge clk) begin
		if (row_we)
			row_mem[row_waddr] <= row_wdata;
		if (state_q == ST_MUL)
			row_rd_q <= row_mem[set_q];
	end

	// group counter memory
	always_ff @(posedge clk) begin
		if (ctr_we)
			ctr_mem[ctr_waddr] <= ctr_wdata;
		if (state_q == ST_GRP)
			ctr_rd_q <= ctr_mem[grp_nx];
	end

	// checks
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_update_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		done && func_q == FUNC_UPDATE |-> victim_way == '0)
		else $error("update returned a victim way");

	a_victim_no_srrip: assert property (@(posedge clk) disable iff (!arst_n)
		done && func_q == FUNC_VICTIM |-> !used_srrip)
		else $error("victim request flagged srrip insertion");

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("bimodal lfsr reached zero");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer did not make the block busy");

endmodule

// File: verif/drrip_cache_replacement_test.sv
// ----------------------------------------------------------------------------
// drrip_cache_replacement_test
// Self-checking bench for the DRRIP replacement block: a queued driver sends
// victim searches, hit updates and miss fills with random gaps, a predictor
// tracks re-reference values, dueling counters and the bimodal LFSR, and a
// monitor compares every result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module drrip_cache_replacement_test;
	import drrip_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SETS     = DEF_NUM_SETS;
	localparam int NUM_WAYS     = DEF_NUM_WAYS;
	localparam int GROUP_SIZE   = DEF_GROUP_SIZE;
	localparam int NUM_GROUPS   = (NUM_SETS + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int CNT_W        = DEF_COUNTER_BITS;
	localparam int RRPV_W       = DEF_RRPV_BITS;
	localparam int BIMODAL_ODDS = DEF_BIMODAL_ODDS;

	localparam logic [RRPV_W-1:0] RRPV_MAX  = {RRPV_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_HALF  = CNT_W'(1) << (CNT_W - 1);

	// even leader that is trained hard so its followers switch to srrip
	localparam int TRAIN_SET    = 2 * GROUP_SIZE;
	localparam int RAND_ITEMS   = 1440;
	localparam int TRAIN_ITEMS  = 900;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		logic                 op;
		logic [SET_IDX_W-1:0] set;
		logic [WAY_IDX_W-1:0] way;
		logic                 hit;
	} access_t;

	typedef struct packed {
		logic [VICTIM_W-1:0] victim;
		logic                srrip;
	} outcome_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 func = 1'b0;
	logic [SET_IDX_W-1:0] set_index = '0;
	logic [WAY_IDX_W-1:0] way_index = '0;
	logic                 hit = 1'b0;
	logic                 done;
	logic [VICTIM_W-1:0]  victim_way;
	logic                 used_srrip;

	// predicted block state
	logic [RRPV_W-1:0] rrpv_mem [NUM_SETS][NUM_WAYS];
	logic [CNT_W-1:0]  duel_ctr [NUM_GROUPS];
	logic [LFSR_W-1:0] bip_lfsr;

	access_t  pending_accesses [$];
	outcome_t expected_outcomes [$];
	access_t  cur_access = '0;
	int       gap_left = 0;
	int       calm_left = 0;
	int       mismatch_count = 0;

	drrip_cache_replacement u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.set_index  (set_index),
		.way_index  (way_index),
		.hit        (hit),
		.done       (done),
		.victim_way (victim_way),
		.used_srrip (used_srrip)
	);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// timeout guard
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// advance the predicted state by one accepted request
	function automatic outcome_t model_access(access_t a);
		outcome_t          r;
		logic [RRPV_W-1:0] top;
		logic [RRPV_W-1:0] bump;
		logic [3:0]        first;
		int                grp;
		int                w;
		logic              srrip;
		r = '0;
		if (a.op == FUNC_VICTIM) begin
			top = '0;
			first = '0;
			for (w = 0; w < NUM_WAYS; w++) begin
				if (rrpv_mem[a.set][w] > top) begin
					top = rrpv_mem[a.set][w];
					first = 4'(w);
				end
			end
			// age the whole set so that the top way reaches the maximum
			if (top < RRPV_MAX) begin
				bump = RRPV_MAX - top;
				for (w = 0; w < NUM_WAYS; w++)
					rrpv_mem[a.set][w] = rrpv_mem[a.set][w] + bump;
			end
			r.victim = first;
		end else if (a.hit) begin
			rrpv_mem[a.set][a.way] = '0;
		end else begin
			grp = a.set / GROUP_SIZE;
			if (a.set % GROUP_SIZE == 0) begin
				// leaders train their group counter
				if (grp % 2 == 0) begin
					srrip = 1'b1;
					if (duel_ctr[grp] < CNT_MAX)
						duel_ctr[grp] = duel_ctr[grp] + 1'b1;
				end else begin
					srrip = 1'b0;
					if (duel_ctr[grp] > 0)
						duel_ctr[grp] = duel_ctr[grp] - 1'b1;
				end
			end else begin
				srrip = duel_ctr[grp] > CNT_HALF;
			end
			if (srrip) begin
				rrpv_mem[a.set][a.way] = RRPV_MAX - 1'b1;
			end else begin
				// bimodal draw from the lfsr
				bip_lfsr = {bip_lfsr[0] ^ bip_lfsr[2] ^ bip_lfsr[3] ^ bip_lfsr[5],
					bip_lfsr[LFSR_W-1:1]};
				if (bip_lfsr % BIMODAL_ODDS == 0)
					rrpv_mem[a.set][a.way] = RRPV_MAX - 1'b1;
				else
					rrpv_mem[a.set][a.way] = RRPV_MAX;
			end
			r.srrip = srrip;
		end
		return r;
	endfunction

	// idle gap after a transfer: calm stretches, mostly short gaps, a few long
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if (r < 5) begin
			calm_left = $urandom_range(10, 60);
			return 0;
		end
		if (r < 40)
			return 0;
		if (r < 92)
			return $urandom_range(1, 6);
		return $urandom_range(7, 30);
	endfunction

	// sets drawn mostly from a small pool so state builds up
	function automatic logic [SET_IDX_W-1:0] pick_set();
		case ($urandom_range(0, 7))
			0: return SET_IDX_W'(TRAIN_SET);
			1, 2: return SET_IDX_W'(TRAIN_SET + $urandom_range(1, 3));
			3: return SET_IDX_W'($urandom_range(0, 3) * GROUP_SIZE);
			4: return SET_IDX_W'($urandom_range(0, 3) * GROUP_SIZE + 1);
			5: return SET_IDX_W'(NUM_SETS - 1 - $urandom_range(0, 1));
			default: return SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
		endcase
	endfunction

	task automatic queue_access(logic op, int set, int way, logic h);
		access_t a;
		a.op = op;
		a.set = SET_IDX_W'(set);
		a.way = WAY_IDX_W'(way);
		a.hit = h;
		pending_accesses = {pending_accesses, a};
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// driver: present the next request, hold it until the transfer
	always @(posedge clk or negedge arst_n) begin
		logic go;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			go = start;
			if (start && !busy) begin
				expected_outcomes = {expected_outcomes, model_access(cur_access)};
				go = 1'b0;
				gap_left = idle_gap();
			end
			if (!go) begin
				if (gap_left > 0)
					gap_left--;
				else if (pending_accesses.size() > 0) begin
					cur_access = pending_accesses.pop_front();
					go = 1'b1;
				end
			end
			start <= go;
			func <= cur_access.op;
			set_index <= cur_access.set;
			way_index <= cur_access.way;
			hit <= cur_access.hit;
		end
	end

	// monitor: each result strobe against the oldest prediction
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				report_mismatch("unexpected result, victim_way", victim_way, 0);
			end else begin
				want = expected_outcomes.pop_front();
				if (victim_way !== want.victim)
					report_mismatch("victim_way", victim_way, want.victim);
				if (used_srrip !== want.srrip)
					report_mismatch("used_srrip", used_srrip, want.srrip);
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int n;
		int s;
		int k;
		int train_pct;
		for (n = 0; n < NUM_SETS; n++)
			for (k = 0; k < NUM_WAYS; k++)
				rrpv_mem[n][k] = RRPV_MAX;
		for (n = 0; n < NUM_GROUPS; n++)
			duel_ctr[n] = '0;
		bip_lfsr = LFSR_SEED;

		// directed: field extremes, leaders of both parities, followers
		queue_access(FUNC_VICTIM, 0, 15, 1'b1);
		queue_access(FUNC_UPDATE, 0, 0, 1'b1);
		queue_access(FUNC_VICTIM, 0, 0, 1'b0);
		queue_access(FUNC_UPDATE, 0, 15, 1'b0);
		queue_access(FUNC_UPDATE, GROUP_SIZE, 3, 1'b0);
		queue_access(FUNC_UPDATE, 1, 0, 1'b0);
		queue_access(FUNC_UPDATE, GROUP_SIZE + 1, 7, 1'b0);
		queue_access(FUNC_UPDATE, NUM_SETS - 1, 15, 1'b1);
		queue_access(FUNC_VICTIM, NUM_SETS - 1, 15, 1'b1);
		queue_access(FUNC_UPDATE, NUM_SETS - 1, 0, 1'b0);
		queue_access(FUNC_VICTIM, NUM_SETS - 1, 0, 1'b0);
		queue_access(FUNC_UPDATE, NUM_SETS - GROUP_SIZE, 15, 1'b0);
		queue_access(FUNC_VICTIM, NUM_SETS / 2, 0, 1'b0);
		queue_access(FUNC_UPDATE, 1365, 10, 1'b1);
		queue_access(FUNC_VICTIM, 682, 5, 1'b0);
		queue_access(FUNC_VICTIM, 1365, 15, 1'b1);

		// random: heavy leader training early, then a broad mix
		for (n = 0; n < RAND_ITEMS; n++) begin
			train_pct = (n < TRAIN_ITEMS) ? 60 : 10;
			if ($urandom_range(0, 99) < train_pct) begin
				queue_access(FUNC_UPDATE, TRAIN_SET, $urandom_range(0, 15), 1'b0);
			end else begin
				s = pick_set();
				k = $urandom_range(0, 9);
				if (k < 4)
					queue_access(FUNC_VICTIM, s, $urandom_range(0, 15),
						1'($urandom_range(0, 1)));
				else if (k < 6)
					queue_access(FUNC_UPDATE, s, $urandom_range(0, 15), 1'b1);
				else
					queue_access(FUNC_UPDATE, s, $urandom_range(0, 15), 1'b0);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// drain: every request sent and every result seen
		while (pending_accesses.size() > 0 || start || expected_outcomes.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
sv/drrip_pkg.sv
sv/drrip_cache_replacement.sv
verif/drrip_cache_replacement_test.sv
